@@ rtl/cps_pkg.sv @@
// ----------------------------------------------------------------------------
// cps_pkg
// Types and constants shared by the charlieplexed LED PWM scanner.
// ----------------------------------------------------------------------------
package cps_pkg;

   localparam int PIN_W     = 3;
   localparam int PATTERN_W = 42;

   typedef enum logic [2:0] {
      REQ_TICK       = 3'd0,
      REQ_WRITE_BIT  = 3'd1,
      REQ_LOAD_MASK  = 3'd2,
      REQ_START_MUX  = 3'd3,
      REQ_STOP_MUX   = 3'd4,
      REQ_SINGLE_LED = 3'd5
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // register select is paddr[2]
   localparam logic CSR_BRIGHTNESS = 1'b0;
   localparam logic CSR_FAST_PWM   = 1'b1;

   typedef struct packed {
      logic [2:0]           req_type;
      logic [5:0]           led_index;
      logic                 led_on;
      logic [PATTERN_W-1:0] pattern;
   } req_data_type;

   typedef struct packed {
      logic             lit;
      logic [PIN_W-1:0] high_pin;
      logic [PIN_W-1:0] low_pin;
      logic [7:0]       pwm_count;
   } rsp_data_type;

endpackage

@@ rtl/charlieplex_pwm_scanner.sv @@
// ----------------------------------------------------------------------------
// charlieplex_pwm_scanner
// PWM counter and round-robin LED scanner for a charlieplexed LED array.
// ----------------------------------------------------------------------------
// Usage: commands arrive as transactions on the req_ channel (valid/stall);
// each one yields exactly one result transaction on the rsp_ channel with the
// lit flag, the anode/cathode logical pins and the PWM counter value.
// The user must write brightness and fast PWM mode over the csr_ APB port
// only while idle; the block does not enforce this. Most commands give
// their result in the cycle after acceptance. A tick that wraps the counter
// to zero while multiplexing is on starts a scan that tests one LED position
// per cycle on a single compare/increment unit; ST_FINISH loads its result.
// The block takes one transaction at a time: req_stall stays high during the
// scan and while a finished result cannot be placed in the output register.
// A result held by rsp_stall still lets a new transaction be taken in the
// cycle the receiver takes the held one.
// Reset: counter, scan position, enable mask, selection and lit flag clear,
// brightness returns to 128 and fast mode to off.
// ----------------------------------------------------------------------------
module charlieplex_pwm_scanner
   import cps_pkg::*;
#(
   parameter int PIN_COUNT   = 7,
   parameter int LED_COUNT   = 42,
   parameter int FAST_PERIOD = 64
) (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,

   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data,

   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int IDX_W = $clog2(LED_COUNT);

   // {has pair, anode, cathode} for one LED number, worked out at elaboration
   function automatic logic [2*PIN_W:0] pair_code(input int idx);
      int k;
      logic [2*PIN_W:0] code;
      k    = 0;
      code = '0;
      for (int a = 0; a < PIN_COUNT - 1; a++) begin
         for (int b = PIN_COUNT - 1; b > a; b--) begin
            if (k == idx) begin
               code = {1'b1, PIN_W'(b), PIN_W'(a)};
            end else if (k + 1 == idx) begin
               code = {1'b1, PIN_W'(a), PIN_W'(b)};
            end
            k = k + 2;
         end
      end
      return code;
   endfunction

   logic             pair_ok [LED_COUNT];
   logic [PIN_W-1:0] pair_an [LED_COUNT];
   logic [PIN_W-1:0] pair_ca [LED_COUNT];

   for (genvar g = 0; g < LED_COUNT; g++) begin : g_pair
      localparam logic [2*PIN_W:0] CODE = pair_code(g);
      assign pair_ok[g] = CODE[2*PIN_W];
      assign pair_an[g] = CODE[2*PIN_W-1:PIN_W];
      assign pair_ca[g] = CODE[PIN_W-1:0];
   end

   state_type             state_ff, state_in;
   logic [7:0]            pwm_ff, pwm_in;
   logic [IDX_W-1:0]      scan_pos_ff, scan_pos_in;
   logic [IDX_W-1:0]      scan_cnt_ff, scan_cnt_in;
   logic [LED_COUNT-1:0]  mask_ff, mask_in;
   logic                  mux_ff, mux_in;
   logic                  sel_valid_ff, sel_valid_in;
   logic [PIN_W-1:0]      sel_an_ff, sel_an_in;
   logic [PIN_W-1:0]      sel_ca_ff, sel_ca_in;
   logic                  lit_ff, lit_in;
   logic [7:0]            bright_ff, bright_in;
   logic                  fast_ff, fast_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_data_type          rsp_data_ff, rsp_data_in;

   logic                  out_free;
   logic                  accept;
   logic                  load;
   logic [8:0]            tick_sum;
   logic [7:0]            tick_next;
   logic [IDX_W-1:0]      pos_next;
   logic [IDX_W-1:0]      req_idx;
   logic                  req_idx_ok;
   logic                  csr_write;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && out_free);
   assign accept     = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign req_idx    = req_data.led_index[IDX_W-1:0];
   assign req_idx_ok = req_data.led_index < 6'(LED_COUNT);

   assign tick_sum   = {1'b0, pwm_ff} + 9'd1;
   assign pos_next   = (scan_pos_ff == IDX_W'(LED_COUNT - 1)) ? '0 : scan_pos_ff + 1'b1;

   always_comb begin
      if (fast_ff && (tick_sum >= 9'(FAST_PERIOD))) begin
         tick_next = '0;
      end else begin
         tick_next = tick_sum[7:0];
      end
   end

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      bright_in = bright_ff;
      fast_in   = fast_ff;
      if (csr_write) begin
         if (csr_paddr[2] == CSR_FAST_PWM) begin
            fast_in = csr_pwdata[0];
         end else begin
            bright_in = csr_pwdata[7:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == CSR_FAST_PWM) begin
         csr_prdata = {31'd0, fast_ff};
      end else begin
         csr_prdata = {24'd0, bright_ff};
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pwm_in       = pwm_ff;
      scan_pos_in  = scan_pos_ff;
      scan_cnt_in  = scan_cnt_ff;
      mask_in      = mask_ff;
      mux_in       = mux_ff;
      sel_valid_in = sel_valid_ff;
      sel_an_in    = sel_an_ff;
      sel_ca_in    = sel_ca_ff;
      lit_in       = lit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      load         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               load = 1'b1;
               unique case (req_data.req_type)
                  REQ_TICK: begin
                     pwm_in = tick_next;
                     if ((tick_next == 8'd0) && mux_ff) begin
                        // wrap with multiplexing on: run the search first
                        lit_in      = 1'b0;
                        scan_cnt_in = '0;
                        state_in    = ST_SCAN;
                        load        = 1'b0;
                     end else if (tick_next < bright_ff) begin
                        lit_in = lit_ff || sel_valid_ff;
                     end else begin
                        lit_in = 1'b0;
                     end
                  end
                  REQ_WRITE_BIT: begin
                     if (req_idx_ok) begin
                        mask_in[req_idx] = req_data.led_on;
                     end
                  end
                  REQ_LOAD_MASK: begin
                     mask_in = LED_COUNT'(req_data.pattern);
                  end
                  REQ_START_MUX: begin
                     mask_in     = LED_COUNT'(req_data.pattern);
                     mux_in      = 1'b1;
                     scan_pos_in = '0;
                  end
                  REQ_STOP_MUX: begin
                     mux_in               = 1'b0;
                     mask_in[scan_pos_ff] = 1'b0;
                  end
                  REQ_SINGLE_LED: begin
                     if (req_idx_ok) begin
                        lit_in = 1'b0;
                        if (req_data.led_on) begin
                           sel_valid_in = pair_ok[req_idx];
                           sel_an_in    = pair_ok[req_idx] ? pair_an[req_idx] : '0;
                           sel_ca_in    = pair_ok[req_idx] ? pair_ca[req_idx] : '0;
                           pwm_in       = '0;
                        end else begin
                           sel_valid_in = 1'b0;
                           sel_an_in    = '0;
                           sel_ca_in    = '0;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // one mask position per cycle
            if (mask_ff[scan_pos_ff]) begin
               sel_valid_in = pair_ok[scan_pos_ff];
               sel_an_in    = pair_ok[scan_pos_ff] ? pair_an[scan_pos_ff] : '0;
               sel_ca_in    = pair_ok[scan_pos_ff] ? pair_ca[scan_pos_ff] : '0;
               scan_pos_in  = pos_next;
               state_in     = ST_FINISH;
            end else if (scan_cnt_ff == IDX_W'(LED_COUNT - 1)) begin
               // full lap without a hit, position is back at its start
               sel_valid_in = 1'b0;
               sel_an_in    = '0;
               sel_ca_in    = '0;
               scan_pos_in  = pos_next;
               state_in     = ST_FINISH;
            end else begin
               scan_pos_in = pos_next;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               lit_in   = (pwm_ff < bright_ff) && sel_valid_ff;
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_data_in = rsp_data_ff;
      if (load) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.lit       = lit_in;
         rsp_data_in.high_pin  = lit_in ? sel_an_in : '0;
         rsp_data_in.low_pin   = lit_in ? sel_ca_in : '0;
         rsp_data_in.pwm_count = pwm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pwm_ff       <= '0;
         scan_pos_ff  <= '0;
         scan_cnt_ff  <= '0;
         mask_ff      <= '0;
         mux_ff       <= 1'b0;
         sel_valid_ff <= 1'b0;
         sel_an_ff    <= '0;
         sel_ca_ff    <= '0;
         lit_ff       <= 1'b0;
         bright_ff    <= 8'd128;
         fast_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pwm_ff       <= pwm_in;
         scan_pos_ff  <= scan_pos_in;
         scan_cnt_ff  <= scan_cnt_in;
         mask_ff      <= mask_in;
         mux_ff       <= mux_in;
         sel_valid_ff <= sel_valid_in;
         sel_an_ff    <= sel_an_in;
         sel_ca_ff    <= sel_ca_in;
         lit_ff       <= lit_in;
         bright_ff    <= bright_in;
         fast_ff      <= fast_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   a_scan_pos_range: assert property (@(posedge clock) disable iff (reset)
      scan_pos_ff < IDX_W'(LED_COUNT))
      else $error("scan position out of range");

   a_scan_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_cnt_ff < IDX_W'(LED_COUNT)))
      else $error("scan ran past a full lap");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("transaction accepted during scan");

   a_lit_needs_sel: assert property (@(posedge clock) disable iff (reset)
      lit_ff |-> sel_valid_ff)
      else $error("lit without a selected led");

   a_scan_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && !rsp_stall |=> !rsp_valid)
      else $error("result produced before scan finished");

endmodule
